// ===== rtl/core/mvpf_pkg.sv =====
// Package for the motor velocity PI + feedforward controller.
// Holds the fixed-point constants, the sequencer state type and the register codes.
// No dependencies.
`default_nettype none

package mvpf_pkg;

  localparam int NUM_MOTORS = 4;

  localparam int MOTOR_W = 2;   // width of the motor index field
  localparam int VEL_W   = 16;  // Q8.8 velocities
  localparam int DT_W    = 16;  // Q0.16 time step
  localparam int GAIN_W  = 16;  // Q8.8 gains
  localparam int DUTY_W  = 8;
  localparam int INTEG_W = 32;  // Q16.16 stored integral

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // |t| at or below this counts as a zero target
  localparam logic [VEL_W:0] SMALL_TARGET_MAX = 17'd2;

  // feedforward = |t| * 2176000 / 113 + 835584, split as
  // |t| * 19256 + floor(|t| * 72 / 113); the second part by reciprocal
  localparam logic [32:0] FF_INT_MUL    = 33'd19256;
  localparam logic [32:0] FF_FRAC_MUL   = 33'd10689908;  // ceil(72 * 2^24 / 113)
  localparam int          FF_FRAC_SHIFT = 24;
  localparam logic [31:0] FF_OFFSET     = 32'd835584;

  // anti-windup bound on ki * I, and output bound (250 in Q16.16)
  localparam logic [30:0] I_LIMIT   = 31'd1677721600;
  localparam int          DIV_STEPS = 31;
  localparam logic [36:0] OUT_LIMIT = 37'd16384000;
  localparam int          DUTY_MAX  = 250;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_DT,    // issue err * dt
    ST_FF_INT,    // integral sum; issue |t| * 19256
    ST_FF_FRAC,   // feedforward base; issue |t| * reciprocal
    ST_PROP,      // feedforward fraction; issue kp * err
    ST_WAIT_DIV,  // latch kp * err, wait for the limit quotient
    ST_CLAMP,     // anti-windup clamp
    ST_INTEG,     // issue ki * I
    ST_SUM,       // add integral term
    ST_FIN        // form duty and direction, write back
  } mvpf_state_t;

  typedef enum logic {
    REG_PROP_GAIN  = 1'b0,
    REG_INTEG_GAIN = 1'b1
  } mvpf_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/motor_velocity_pi_feedforward.sv =====
// Top level of the motor velocity PI controller with feedforward and anti-windup.
// Depends on mvpf_pkg; one shared multiplier and one bit-serial divider under a sequencer.
`default_nettype none

// Takes one transaction at a time: a motor index, target and measured velocity
// (signed Q8.8) and a time step (Q0.16). Gives one transaction per input with the
// duty count (0..250), the direction and the motor index. The limit quotient
// 100*2^24/ki comes from a restoring divider that retires one quotient bit per
// cycle; the err*dt, feedforward and kp*err products go through one registered
// 17x33 multiplier while the divider runs, and the ki*I product after it. A target
// with |t| <= 2, or a motor index of NUM_MOTORS or more, bypasses the arithmetic.
// The result sits in an output register, so a pending result does not block
// acceptance of the next item. Gains are written on the cfg port; the user must
// write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high. Integrals and stored directions reset to zero / forward.
module motor_velocity_pi_feedforward
  import mvpf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] motor_index, [17:2] target_velocity, [33:18] measured_velocity,
  // [49:34] time_step, [55:50] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] duty_count, [8] reverse, [10:9] result_motor, [15:11] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [GAIN_W-1:0]      cfg_data
);

  // configuration
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] integ_gain_r;

  // per-motor state
  logic signed [INTEG_W-1:0] integ_store_r [NUM_MOTORS];
  logic                      dir_store_r   [NUM_MOTORS];

  // sequencer
  mvpf_state_t state_r, state_nxt;

  // item registers
  logic [MOTOR_W-1:0]  idx_r;
  logic                idx_ok_r;
  logic                small_r;
  logic                tpos_r;
  logic [VEL_W:0]      tabs_r;
  logic signed [VEL_W:0] err_r;
  logic [DT_W-1:0]     dt_r;

  // datapath registers
  logic signed [49:0]  prod_r;
  logic signed [32:0]  integ_r;
  logic signed [31:0]  ff_r;
  logic signed [35:0]  pi_r;

  // divider
  logic [4:0]          div_cnt_r;
  logic [30:0]         div_num_r;   // dividend shifts out, quotient shifts in
  logic [15:0]         div_rem_r;
  logic [16:0]         div_try;
  logic                div_ge;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // control strobes from the sequencer
  logic                 accept;
  logic                 mul_en;
  logic signed [16:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic                 fin_go;

  // input field views
  logic [MOTOR_W-1:0]      in_idx;
  logic signed [VEL_W-1:0] in_t;
  logic signed [VEL_W-1:0] in_m;
  logic [DT_W-1:0]         in_dt;
  logic signed [VEL_W:0]   in_t_ext;
  logic [VEL_W:0]          in_tabs;

  assign in_idx   = in_tdata[1:0];
  assign in_t     = in_tdata[17:2];
  assign in_m     = in_tdata[33:18];
  assign in_dt    = in_tdata[49:34];
  assign in_t_ext = {in_t[VEL_W-1], in_t};
  assign in_tabs  = in_t[VEL_W-1] ? 17'(-in_t_ext) : 17'(in_t_ext);

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mvpf_reg_t'(cfg_index))
        REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        REG_INTEG_GAIN: integ_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tabs <= SMALL_TARGET_MAX || 32'(in_idx) >= NUM_MOTORS) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ERR_DT;
          end
        end
      end
      ST_ERR_DT:   state_nxt = ST_FF_INT;
      ST_FF_INT:   state_nxt = ST_FF_FRAC;
      ST_FF_FRAC:  state_nxt = ST_PROP;
      ST_PROP:     state_nxt = ST_WAIT_DIV;
      ST_WAIT_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP:    state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_FIN;
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    fin_go = 1'b0;
    case (state_r)
      ST_ERR_DT: begin
        mul_en = 1'b1;
        mul_a  = err_r;
        mul_b  = $signed({17'd0, dt_r});
      end
      ST_FF_INT: begin
        mul_en = 1'b1;
        mul_a  = $signed(tabs_r);
        mul_b  = $signed(FF_INT_MUL);
      end
      ST_FF_FRAC: begin
        mul_en = 1'b1;
        mul_a  = $signed(tabs_r);
        mul_b  = $signed(FF_FRAC_MUL);
      end
      ST_PROP: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, prop_gain_r});
        mul_b  = 33'(err_r);
      end
      ST_INTEG: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, integ_gain_r});
        mul_b  = integ_r;
      end
      ST_FIN: begin
        fin_go = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= 50'(mul_a) * 50'(mul_b);
    end
  end

  // -------------------------------------------------------------- divider
  // restoring division of I_LIMIT by ki, one quotient bit per cycle
  assign div_try = {div_rem_r, div_num_r[30]};
  assign div_ge  = (div_try >= {1'b0, integ_gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (accept) begin
      div_cnt_r <= 5'(DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      div_num_r <= I_LIMIT;
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      div_num_r <= {div_num_r[29:0], div_ge};
      div_rem_r <= div_ge ? 16'(div_try - {1'b0, integ_gain_r}) : div_try[15:0];
    end
  end

  // ------------------------------------------------------------- datapath
  logic signed [32:0] q_s;
  assign q_s = $signed({2'b00, div_num_r});

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= in_idx;
      idx_ok_r <= 32'(in_idx) < NUM_MOTORS;
      small_r  <= in_tabs <= SMALL_TARGET_MAX;
      tpos_r   <= !in_t[VEL_W-1] && (in_t != '0);
      tabs_r   <= in_tabs;
      err_r    <= in_t_ext - {in_m[VEL_W-1], in_m};
      dt_r     <= in_dt;
    end
    case (state_r)
      ST_FF_INT: begin
        integ_r <= 33'(integ_store_r[idx_r]) + 33'(prod_r >>> 8);
      end
      ST_FF_FRAC: begin
        ff_r <= prod_r[31:0] + FF_OFFSET;
      end
      ST_PROP: begin
        ff_r <= ff_r + 32'(prod_r >>> FF_FRAC_SHIFT);
      end
      ST_WAIT_DIV: begin
        pi_r <= prod_r[35:0];
      end
      ST_CLAMP: begin
        if (integ_gain_r == '0) begin
          integ_r <= '0;
        end else if (integ_r > q_s) begin
          integ_r <= q_s;
        end else if (integ_r < -q_s) begin
          integ_r <= -q_s;
        end
      end
      ST_SUM: begin
        pi_r <= pi_r + 36'(prod_r >>> 8);
      end
      default: ;
    endcase
  end

  // final sum, sign hold and limit
  logic signed [36:0] f_raw;
  logic signed [36:0] f_held;
  logic signed [36:0] f_lim;
  logic               f_rev;
  logic [36:0]        f_mag;

  always_comb begin
    if (tpos_r) begin
      f_raw  = 37'(ff_r) + 37'(pi_r);
      f_held = (f_raw < 0) ? '0 : f_raw;
    end else begin
      f_raw  = 37'(pi_r) - 37'(ff_r);
      f_held = (f_raw > 0) ? '0 : f_raw;
    end
    if (f_held > $signed(OUT_LIMIT)) begin
      f_lim = $signed(OUT_LIMIT);
    end else if (f_held < -$signed(OUT_LIMIT)) begin
      f_lim = -$signed(OUT_LIMIT);
    end else begin
      f_lim = f_held;
    end
    f_rev = f_lim[36];
    f_mag = f_rev ? 37'(-f_lim) : 37'(f_lim);
  end

  // per-motor state write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        integ_store_r[k] <= '0;
        dir_store_r[k]   <= 1'b0;
      end
    end else if (fin_go && idx_ok_r) begin
      if (small_r) begin
        integ_store_r[idx_r] <= '0;
      end else begin
        integ_store_r[idx_r] <= integ_r[31:0];
        dir_store_r[idx_r]   <= f_rev;
      end
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (!idx_ok_r) begin
        out_data_r <= {5'd0, idx_r, 1'b0, 8'd0};
      end else if (small_r) begin
        out_data_r <= {5'd0, idx_r, dir_store_r[idx_r], 8'd0};
      end else begin
        out_data_r <= {5'd0, idx_r, f_rev, f_mag[23:16]};
      end
    end
  end

  // ----------------------------------------------------------- assertions
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("item accepted while another is in progress");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP) |-> (div_cnt_r == '0))
    else $error("clamp used an unfinished quotient");

  a_windup_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INTEG && integ_gain_r != '0) |-> (integ_r <= q_s && integ_r >= -q_s))
    else $error("integral outside anti-windup bound");

  a_zero_ki: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INTEG && integ_gain_r == '0) |-> (integ_r == '0))
    else $error("integral not cleared with zero integral gain");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[7:0] <= 8'(DUTY_MAX)))
    else $error("duty count above limit");

endmodule

`default_nettype wire
